FILE: hw/rtl/csdm_pkg.sv
package csdm_pkg;

  localparam int COORD_WIDTH    = 20;
  localparam int TRIG_FRAC_BITS = 22;
  localparam int TRIG_WIDTH     = TRIG_FRAC_BITS + 2;
  localparam int COORD_FRAC     = 8;

  localparam int REG_WIDTH  = 20;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 2 * TRIG_WIDTH;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_RADIUS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAPER_COEF  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEG_LENGTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_SCALE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIG_THETA  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIG_PSI    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIG_ALPHA  = 3'd6;

  // saturated coordinate, signed
  localparam int CSW  = COORD_WIDTH + 1;
  // coordinate times cos/sin, then rounded back to Q.8, then summed
  localparam int PW   = CSW + TRIG_WIDTH;
  localparam int RPW  = PW - TRIG_FRAC_BITS;
  localparam int SUMW = RPW + 1;
  // x times inv_scale, and its Q.8 value
  localparam int XSW  = CSW + REG_WIDTH + 1;
  localparam int AW   = XSW - 16;
  // taper product, radius
  localparam int CLW  = CSW + REG_WIDTH;
  localparam int SGW  = CSW + 9;
  localparam int SW   = SGW;
  // squares and divider remainder
  localparam int DW   = 2 * AW + 1;
  localparam int S2W  = 2 * SW;
  localparam int RW   = S2W + 1;
  // slab compare
  localparam int BW   = ((CSW > REG_WIDTH) ? CSW : REG_WIDTH) + 2;

  localparam int QW          = 32;
  localparam int DIV_STEPS   = QW;
  localparam int SQRT_STEPS  = QW / 2;
  localparam int SQW         = QW + 1;
  localparam int N_FRONT     = 10;
  localparam int N_STAGES    = N_FRONT + DIV_STEPS + SQRT_STEPS + 1;
  localparam int OUT_W       = 16;

  localparam logic signed [PW-1:0]   RND_T  = PW'(1) << (TRIG_FRAC_BITS - 1);
  localparam logic signed [CLW-1:0]  RND_12 = CLW'(1) << 11;
  localparam logic signed [XSW-1:0]  RND_16 = XSW'(1) << 15;
  localparam logic signed [SUMW-1:0] SAT_LIM = SUMW'((64'd1 << COORD_WIDTH) - 64'd1);
  localparam logic signed [BW-1:0]   SLAB_HALF = BW'(1) << (COORD_FRAC - 1);

  localparam logic [OUT_W-1:0] OUTSIDE_VALUE = 16'd8192;
  localparam logic [OUT_W-1:0] SAT_VALUE     = 16'hFFFF;

  typedef struct packed {
    logic beyond;
    logic sat;
  } flags_t;

endpackage

FILE: hw/rtl/csdm_if.sv
interface csdm_pix_if;
  logic valid;
  logic ready;
  logic signed [csdm_pkg::COORD_WIDTH-1:0] pos_x;
  logic signed [csdm_pkg::COORD_WIDTH-1:0] pos_y;
  logic signed [csdm_pkg::COORD_WIDTH-1:0] pos_z;
  modport source (output valid, pos_x, pos_y, pos_z, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

interface csdm_res_if;
  logic valid;
  logic ready;
  logic [csdm_pkg::OUT_W-1:0] norm_dist;
  logic beyond_length;
  modport source (output valid, norm_dist, beyond_length, input ready);
  modport sink (input valid, norm_dist, beyond_length, output ready);
endinterface

interface csdm_cfg_if;
  logic valid;
  logic ready;
  logic [csdm_pkg::CFG_IDX_W-1:0] index;
  logic [csdm_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/cone_segment_distance_map_top.sv
// Normalized distance of a voxel from the axis of a tapered elliptic segment.
// One item is taken every cycle when the output is not stalled; the datapath is
// fully pipelined: ten stages of rotation, scaling and radius arithmetic, a
// 32-stage restoring divider (one quotient bit per stage) and a 16-stage
// integer square root (one result bit per stage). Each stage holds its item
// until the next one is free, so bubbles are squeezed out and a stalled output
// does not stop input while empty stages remain. Registers are written through
// the configuration channel (always ready) and must only change while no item
// is in flight.
module cone_segment_distance_map_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  csdm_pix_if.sink     pix_i,
  csdm_res_if.source   res_o,
  csdm_cfg_if.sink     cfg_i
);

  localparam int NSTG = csdm_pkg::N_STAGES;
  localparam int CSW  = csdm_pkg::CSW;
  localparam int PW   = csdm_pkg::PW;
  localparam int RPW  = csdm_pkg::RPW;
  localparam int SUMW = csdm_pkg::SUMW;
  localparam int TW   = csdm_pkg::TRIG_WIDTH;
  localparam int TF   = csdm_pkg::TRIG_FRAC_BITS;
  localparam int RGW  = csdm_pkg::REG_WIDTH;
  localparam int XSW  = csdm_pkg::XSW;
  localparam int AW   = csdm_pkg::AW;
  localparam int CLW  = csdm_pkg::CLW;
  localparam int SGW  = csdm_pkg::SGW;
  localparam int SW   = csdm_pkg::SW;
  localparam int DW   = csdm_pkg::DW;
  localparam int S2W  = csdm_pkg::S2W;
  localparam int RW   = csdm_pkg::RW;
  localparam int BW   = csdm_pkg::BW;
  localparam int QW   = csdm_pkg::QW;
  localparam int SQW  = csdm_pkg::SQW;
  localparam int NF   = csdm_pkg::N_FRONT;
  localparam int NDIV = csdm_pkg::DIV_STEPS;
  localparam int NSQ  = csdm_pkg::SQRT_STEPS;

  function automatic logic signed [RPW-1:0] rnd_t(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] t;
    t = p + csdm_pkg::RND_T;
    return t[PW-1:TF];
  endfunction

  function automatic logic signed [CSW-1:0] sat_c(input logic signed [SUMW-1:0] v);
    logic signed [SUMW-1:0] r;
    if (v > csdm_pkg::SAT_LIM) r = csdm_pkg::SAT_LIM;
    else if (v < -csdm_pkg::SAT_LIM) r = -csdm_pkg::SAT_LIM;
    else r = v;
    return r[CSW-1:0];
  endfunction

  function automatic logic signed [CSW-1:0] add_t(input logic signed [PW-1:0] a,
                                                  input logic signed [PW-1:0] b);
    return sat_c(SUMW'(rnd_t(a)) + SUMW'(rnd_t(b)));
  endfunction

  function automatic logic signed [CSW-1:0] sub_t(input logic signed [PW-1:0] a,
                                                  input logic signed [PW-1:0] b);
    return sat_c(SUMW'(rnd_t(a)) - SUMW'(rnd_t(b)));
  endfunction

  // configuration registers
  logic [RGW-1:0] base_radius_q, taper_coef_q, seg_length_q, inv_scale_q;
  logic [2*TW-1:0] trig_theta_q, trig_psi_q, trig_alpha_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_radius_q <= RGW'(4096);
      taper_coef_q  <= '0;
      seg_length_q  <= RGW'(2816);
      inv_scale_q   <= RGW'(65536);
      trig_theta_q  <= (2*TW)'(1) << TF;
      trig_psi_q    <= (2*TW)'(1) << TF;
      trig_alpha_q  <= (2*TW)'(1) << TF;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        csdm_pkg::CFG_BASE_RADIUS: base_radius_q <= cfg_i.data[RGW-1:0];
        csdm_pkg::CFG_TAPER_COEF:  taper_coef_q  <= cfg_i.data[RGW-1:0];
        csdm_pkg::CFG_SEG_LENGTH:  seg_length_q  <= cfg_i.data[RGW-1:0];
        csdm_pkg::CFG_INV_SCALE:   inv_scale_q   <= cfg_i.data[RGW-1:0];
        csdm_pkg::CFG_TRIG_THETA:  trig_theta_q  <= cfg_i.data[2*TW-1:0];
        csdm_pkg::CFG_TRIG_PSI:    trig_psi_q    <= cfg_i.data[2*TW-1:0];
        csdm_pkg::CFG_TRIG_ALPHA:  trig_alpha_q  <= cfg_i.data[2*TW-1:0];
        default: ;
      endcase
    end
  end

  logic signed [TW-1:0] ct, st, cp, sp, ca, sa;
  assign ct = trig_theta_q[TW-1:0];
  assign st = trig_theta_q[2*TW-1:TW];
  assign cp = trig_psi_q[TW-1:0];
  assign sp = trig_psi_q[2*TW-1:TW];
  assign ca = trig_alpha_q[TW-1:0];
  assign sa = trig_alpha_q[2*TW-1:TW];

  // stage valids and load enables; a stage loads when empty or when its
  // successor loads
  logic [NSTG-1:0] vld_q;
  logic [NSTG:0]   en;

  always_comb begin
    en[NSTG] = res_o.ready;
    for (int k = NSTG - 1; k >= 0; k--) begin
      en[k] = ~vld_q[k] | en[k+1];
    end
  end

  assign pix_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (en[k]) begin
          vld_q[k] <= (k == 0) ? pix_i.valid : vld_q[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  // stage 0: first rotation products
  logic signed [PW-1:0] a_pxcp_q, a_pysp_q, a_pycp_q, a_pxsp_q;
  logic signed [csdm_pkg::COORD_WIDTH-1:0] a_pz_q;
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      a_pxcp_q <= PW'(pix_i.pos_x) * PW'(cp);
      a_pysp_q <= PW'(pix_i.pos_y) * PW'(sp);
      a_pycp_q <= PW'(pix_i.pos_y) * PW'(cp);
      a_pxsp_q <= PW'(pix_i.pos_x) * PW'(sp);
      a_pz_q   <= pix_i.pos_z;
    end
  end

  // stage 1
  logic signed [CSW-1:0] b_r0_q, b_r1_q;
  logic signed [csdm_pkg::COORD_WIDTH-1:0] b_pz_q;
  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      b_r0_q <= add_t(a_pxcp_q, a_pysp_q);
      b_r1_q <= sub_t(a_pycp_q, a_pxsp_q);
      b_pz_q <= a_pz_q;
    end
  end

  // stage 2: theta products
  logic signed [PW-1:0] c_ctpz_q, c_str1_q, c_stpz_q, c_ctr1_q;
  logic signed [CSW-1:0] c_r0_q;
  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      c_ctpz_q <= PW'(b_pz_q) * PW'(ct);
      c_str1_q <= PW'(b_r1_q) * PW'(st);
      c_stpz_q <= PW'(b_pz_q) * PW'(st);
      c_ctr1_q <= PW'(b_r1_q) * PW'(ct);
      c_r0_q   <= b_r0_q;
    end
  end

  // stage 3
  logic signed [CSW-1:0] d_lz_q, d_ly_q, d_r0_q;
  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      d_lz_q <= sub_t(c_ctpz_q, c_str1_q);
      d_ly_q <= add_t(c_stpz_q, c_ctr1_q);
      d_r0_q <= c_r0_q;
    end
  end

  // stage 4: alpha products, taper product, slab test
  logic signed [PW-1:0]  e_r0ca_q, e_lysa_q, e_lyca_q, e_r0sa_q;
  logic signed [CLW-1:0] e_clz_q;
  logic                  e_bey_q;
  logic signed [BW-1:0]  lz_ext, slab_hi;
  assign lz_ext  = BW'(d_lz_q);
  assign slab_hi = $signed(BW'(seg_length_q)) - csdm_pkg::SLAB_HALF;
  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      e_r0ca_q <= PW'(d_r0_q) * PW'(ca);
      e_lysa_q <= PW'(d_ly_q) * PW'(sa);
      e_lyca_q <= PW'(d_ly_q) * PW'(ca);
      e_r0sa_q <= PW'(d_r0_q) * PW'(sa);
      e_clz_q  <= CLW'($signed(taper_coef_q)) * CLW'(d_lz_q);
      e_bey_q  <= (lz_ext < -csdm_pkg::SLAB_HALF) || (lz_ext > slab_hi);
    end
  end

  // stage 5
  logic signed [CSW-1:0] f_xr_q, f_lyy_q;
  logic signed [SGW-1:0] f_sig_q;
  logic                  f_bey_q;
  logic signed [CLW-1:0] clz_rnd;
  assign clz_rnd = e_clz_q + csdm_pkg::RND_12;
  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      f_xr_q  <= add_t(e_r0ca_q, e_lysa_q);
      f_lyy_q <= sub_t(e_lyca_q, e_r0sa_q);
      f_sig_q <= SGW'($signed({1'b0, base_radius_q})) + SGW'($signed(clz_rnd[CLW-1:12]));
      f_bey_q <= e_bey_q;
    end
  end

  // stage 6: scale x, radius magnitude
  logic signed [XSW-1:0] g_xs_q;
  logic signed [CSW-1:0] g_lyy_q;
  logic [SW-1:0]         g_s_q;
  logic                  g_bey_q;
  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      g_xs_q  <= XSW'(f_xr_q) * XSW'($signed({1'b0, inv_scale_q}));
      g_lyy_q <= f_lyy_q;
      g_s_q   <= SW'(f_sig_q[SGW-1] ? -f_sig_q : f_sig_q);
      g_bey_q <= f_bey_q;
    end
  end

  // stage 7: magnitudes
  logic [AW-1:0]         h_ax_q, h_ay_q;
  logic [SW-1:0]         h_s_q;
  logic                  h_bey_q;
  logic signed [XSW-1:0] xs_rnd;
  logic signed [AW-1:0]  lx;
  assign xs_rnd = g_xs_q + csdm_pkg::RND_16;
  assign lx     = xs_rnd[XSW-1:16];
  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      h_ax_q  <= lx[AW-1] ? AW'(-lx) : AW'(lx);
      h_ay_q  <= g_lyy_q[CSW-1] ? AW'(-g_lyy_q) : AW'(g_lyy_q);
      h_s_q   <= g_s_q;
      h_bey_q <= g_bey_q;
    end
  end

  // stage 8: squares, early saturation
  logic [2*AW-1:0]        i_ax2_q, i_ay2_q;
  logic [S2W-1:0]         i_s2_q;
  csdm_pkg::flags_t       i_fl_q;
  always_ff @(posedge clk_i) begin
    if (en[8]) begin
      i_ax2_q       <= (2*AW)'(h_ax_q) * (2*AW)'(h_ax_q);
      i_ay2_q       <= (2*AW)'(h_ay_q) * (2*AW)'(h_ay_q);
      i_s2_q        <= S2W'(h_s_q) * S2W'(h_s_q);
      i_fl_q.beyond <= h_bey_q;
      i_fl_q.sat    <= (h_s_q == '0) || (SW'(h_ax_q) >= h_s_q) || (SW'(h_ay_q) >= h_s_q);
    end
  end

  // stage 9 feeds the divider: its registers are entry 0 of the divider arrays
  logic [RW-1:0]    dv_rem_q [NDIV+1];
  logic [S2W-1:0]   dv_s2_q  [NDIV+1];
  logic [QW-1:0]    dv_quo_q [NDIV+1];
  csdm_pkg::flags_t dv_fl_q  [NDIV+1];
  logic [DW-1:0]    d_sum;
  assign d_sum = DW'(i_ax2_q) + DW'(i_ay2_q);

  always_ff @(posedge clk_i) begin
    if (en[NF-1]) begin
      dv_rem_q[0]       <= RW'(d_sum);
      dv_s2_q[0]        <= i_s2_q;
      dv_quo_q[0]       <= '0;
      dv_fl_q[0].beyond <= i_fl_q.beyond;
      dv_fl_q[0].sat    <= i_fl_q.sat || (RW'(d_sum) >= RW'(i_s2_q));
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar i = 0; i < NDIV; i++) begin : g_div
    logic [RW-1:0] rem2;
    logic          take;
    assign rem2 = {dv_rem_q[i][RW-2:0], 1'b0};
    assign take = rem2 >= RW'(dv_s2_q[i]);
    always_ff @(posedge clk_i) begin
      if (en[NF+i]) begin
        dv_rem_q[i+1] <= take ? rem2 - RW'(dv_s2_q[i]) : rem2;
        dv_quo_q[i+1] <= {dv_quo_q[i][QW-2:0], take};
        dv_s2_q[i+1]  <= dv_s2_q[i];
        dv_fl_q[i+1]  <= dv_fl_q[i];
      end
    end
  end

  // integer square root, one result bit per stage
  logic [SQW-1:0]   sq_val_q [NSQ];
  logic [SQW-1:0]   sq_res_q [NSQ];
  csdm_pkg::flags_t sq_fl_q  [NSQ];

  for (genvar j = 0; j < NSQ; j++) begin : g_sqrt
    localparam logic [SQW-1:0] BIT = SQW'(1) << (QW - 2 - 2*j);
    logic [SQW-1:0]   src_val, src_res, trial;
    csdm_pkg::flags_t src_fl;
    if (j == 0) begin : g_first
      assign src_val = SQW'(dv_quo_q[NDIV]);
      assign src_res = '0;
      assign src_fl  = dv_fl_q[NDIV];
    end else begin : g_next
      assign src_val = sq_val_q[j-1];
      assign src_res = sq_res_q[j-1];
      assign src_fl  = sq_fl_q[j-1];
    end
    assign trial = src_res + BIT;
    always_ff @(posedge clk_i) begin
      if (en[NF+NDIV+j]) begin
        if (src_val >= trial) begin
          sq_val_q[j] <= src_val - trial;
          sq_res_q[j] <= (src_res >> 1) + BIT;
        end else begin
          sq_val_q[j] <= src_val;
          sq_res_q[j] <= src_res >> 1;
        end
        sq_fl_q[j] <= src_fl;
      end
    end
  end

  // output register
  logic [csdm_pkg::OUT_W-1:0] out_dist_q;
  logic                       out_bey_q;
  always_ff @(posedge clk_i) begin
    if (en[NSTG-1]) begin
      out_bey_q <= sq_fl_q[NSQ-1].beyond;
      if (sq_fl_q[NSQ-1].beyond) begin
        out_dist_q <= csdm_pkg::OUTSIDE_VALUE;
      end else if (sq_fl_q[NSQ-1].sat) begin
        out_dist_q <= csdm_pkg::SAT_VALUE;
      end else begin
        out_dist_q <= sq_res_q[NSQ-1][csdm_pkg::OUT_W-1:0];
      end
    end
  end

  assign res_o.valid         = vld_q[NSTG-1];
  assign res_o.norm_dist     = out_dist_q;
  assign res_o.beyond_length = out_bey_q;

endmodule
